// ===== design/ghp_pkg.sv =====
// Shared types and constants for the grayscale histogram with peak.
`timescale 1ns / 1ps
package ghp_pkg;

  localparam int BINS_DEF       = 256;
  localparam int COUNT_BITS_DEF = 20;
  localparam int PIXEL_W        = 8;
  localparam int ACTION_W       = 2;
  localparam int OUT_W          = 20;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_READ
  } state_t;

  typedef struct packed {
    logic load;
    logic sel_pixel;
    logic add_wr;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ghp_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps
interface ghp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ghp_pkg::ACTION_W-1:0] action;
  logic [ghp_pkg::PIXEL_W-1:0]  pixel;
  logic [ghp_pkg::PIXEL_W-1:0]  bin_index;

  modport source (output valid, action, pixel, bin_index, input ready);
  modport sink (input valid, action, pixel, bin_index, output ready);
endinterface

interface ghp_out_if;
  logic                      valid;
  logic                      ready;
  logic [ghp_pkg::OUT_W-1:0] bin_count;
  logic [ghp_pkg::OUT_W-1:0] peak_count;

  modport source (output valid, bin_count, peak_count, input ready);
  modport sink (input valid, bin_count, peak_count, output ready);
endinterface

// ===== design/gray_histogram_with_peak.sv =====
// Top level of the grayscale histogram with running peak.
//
//   channel  dir  fields                       word
//   req      in   action, pixel, bin_index     add / read / clear
//   rsp      out  bin_count, peak_count        one per read
//
// An add reads the bin memory, then increments and writes the bin back.
// A read fetches the bin, and the result sits in an output register, so the next
// word is taken while it waits, and a second read holds until it drains.
// A clear sweeps the bin memory one entry a cycle.
// After reset the same sweep runs with req.ready low.
`timescale 1ns / 1ps
module gray_histogram_with_peak #(
  parameter int BINS       = ghp_pkg::BINS_DEF,
  parameter int COUNT_BITS = ghp_pkg::COUNT_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ghp_in_if.sink   req,
  ghp_out_if.source rsp
);
  import ghp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ghp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .action   (req.action),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ghp_datapath #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .pixel      (req.pixel),
    .bin_index  (req.bin_index),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .bin_count  (rsp.bin_count),
    .peak_count (rsp.peak_count)
  );

endmodule

// ===== design/ghp_ctrl.sv =====
// Controller state machine: accept, read-modify-write, result and clear sequencing.
`timescale 1ns / 1ps
module ghp_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [ghp_pkg::ACTION_W-1:0] action,
  output logic                         in_ready,
  input  ghp_pkg::sts_t                sts,
  output ghp_pkg::cmd_t                cmd
);
  import ghp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (action)
            ACT_ADD:   state_next = ST_ADD;
            ACT_READ:  state_next = ST_READ;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        state_next = ST_IDLE;
      end
      ST_READ: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.sel_pixel = (action == ACT_ADD);
    unique case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ADD:   cmd.add_wr = 1'b1;
      ST_READ:  cmd.out_load = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/ghp_datapath.sv =====
// Datapath: bin memory, saturating increment, peak register, sweep counter, output register.
`timescale 1ns / 1ps
module ghp_datapath #(
  parameter int BINS       = ghp_pkg::BINS_DEF,
  parameter int COUNT_BITS = ghp_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ghp_pkg::cmd_t               cmd,
  output ghp_pkg::sts_t               sts,
  input  logic [ghp_pkg::PIXEL_W-1:0] pixel,
  input  logic [ghp_pkg::PIXEL_W-1:0] bin_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ghp_pkg::OUT_W-1:0]   bin_count,
  output logic [ghp_pkg::OUT_W-1:0]   peak_count
);
  import ghp_pkg::*;

  localparam int AW    = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int IDX_W = (AW > PIXEL_W) ? AW : PIXEL_W;
  localparam int CMP_W = IDX_W + 1;
  localparam int CX    = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  logic [COUNT_BITS-1:0] mem [BINS];
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] inc;
  logic [COUNT_BITS-1:0] peak;
  logic [AW-1:0]         addr;
  logic [AW-1:0]         addr_d;
  logic [AW-1:0]         clr_cnt;
  logic                  hit;
  logic                  hit_d;
  logic [IDX_W-1:0]      idx_ext;
  logic [CX-1:0]         rd_wide;
  logic [CX-1:0]         peak_wide;

  assign idx_ext   = cmd.sel_pixel ? IDX_W'(pixel) : IDX_W'(bin_index);
  assign hit_d     = CMP_W'(idx_ext) < CMP_W'(BINS);
  assign addr_d    = idx_ext[AW-1:0];
  assign inc       = (rd_data == {COUNT_BITS{1'b1}}) ? rd_data : rd_data + 1'b1;
  assign rd_wide   = CX'(rd_data);
  assign peak_wide = CX'(peak);

  assign sts.clr_last = (clr_cnt == AW'(BINS - 1));
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt] <= '0;
    end else if (cmd.add_wr && hit) begin
      mem[addr] <= inc;
    end
    if (cmd.load) begin
      rd_data <= mem[addr_d];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= addr_d;
      hit  <= hit_d;
    end
    if (cmd.clr_wr) begin
      peak <= '0;
    end else if (cmd.add_wr && hit && (inc > peak)) begin
      peak <= inc;
    end
    if (cmd.out_load) begin
      bin_count  <= hit ? rd_wide[OUT_W-1:0] : '0;
      peak_count <= peak_wide[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= sts.clr_last ? '0 : clr_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/ghp_checker.sv =====
// Port-level checks for the grayscale histogram, bound to the top level.
`timescale 1ns / 1ps
module ghp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [ghp_pkg::ACTION_W-1:0] req_action,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ghp_pkg::OUT_W-1:0]    bin_count,
  input logic [ghp_pkg::OUT_W-1:0]    peak_count
);
  import ghp_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(bin_count) && $stable(peak_count))
    else $error("result word changed while stalled");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("ready high during post-reset clear");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == ACT_CLEAR) |=> !req_ready)
    else $error("ready high right after clear accepted");

  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == ACT_ADD) |=> !req_ready)
    else $error("ready high during add write-back");

endmodule

bind gray_histogram_with_peak ghp_checker u_ghp_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .bin_count  (rsp.bin_count),
  .peak_count (rsp.peak_count)
);

// ===== verif/tb_gray_histogram_with_peak.sv =====
// Testbench for gray_histogram_with_peak: directed table, then random words.
`timescale 1ns / 1ps
module tb_gray_histogram_with_peak;
  import ghp_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [OUT_W-1:0] COUNT_TOP = '1;
  localparam int RANDOM_WORDS = 700;
  localparam int CALM_FIRST = 250;
  localparam int CALM_LAST = 400;
  localparam int IDLE_PCT = 19;
  localparam int DRAIN_CYCLES = BINS_DEF + 40;
  localparam int PLAN_ROWS = 24;

  typedef struct packed {
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] peak_count;
  } read_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PIXEL_W-1:0]  pixel;
    logic [PIXEL_W-1:0]  bin_index;
    logic                typed;
    logic [OUT_W-1:0]    bin_count;
    logic [OUT_W-1:0]    peak_count;
  } row_t;

  logic clk;
  logic rst;

  ghp_in_if req();
  ghp_out_if rsp();

  gray_histogram_with_peak u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  logic [OUT_W-1:0] hist_bins [BINS_DEF];
  logic [OUT_W-1:0] hist_peak;
  read_t            pending_reads [$];
  int               errors = 0;
  bit               calm = 1'b0;

  row_t plan [PLAN_ROWS] = '{
    '{ACT_READ,  8'h00, 8'h00, 1'b1, 20'd0, 20'd0},
    '{ACT_READ,  8'h00, 8'hFF, 1'b1, 20'd0, 20'd0},
    '{ACT_ADD,   8'h00, 8'h00, 1'b0, 20'd0, 20'd0},
    '{ACT_ADD,   8'hFF, 8'h00, 1'b0, 20'd0, 20'd0},
    '{ACT_ADD,   8'hFF, 8'hFF, 1'b0, 20'd0, 20'd0},
    '{ACT_READ,  8'h00, 8'hFF, 1'b1, 20'd2, 20'd2},
    '{ACT_READ,  8'hFF, 8'h00, 1'b1, 20'd1, 20'd2},
    '{ACT_SPARE, 8'hFF, 8'hFF, 1'b0, 20'd0, 20'd0},
    '{ACT_READ,  8'h00, 8'hFF, 1'b1, 20'd2, 20'd2},
    '{ACT_ADD,   8'h55, 8'hAA, 1'b0, 20'd0, 20'd0},
    '{ACT_READ,  8'hAA, 8'h55, 1'b1, 20'd1, 20'd2},
    '{ACT_ADD,   8'hAA, 8'h55, 1'b0, 20'd0, 20'd0},
    '{ACT_ADD,   8'hAA, 8'h55, 1'b0, 20'd0, 20'd0},
    '{ACT_ADD,   8'hAA, 8'h55, 1'b0, 20'd0, 20'd0},
    '{ACT_READ,  8'h55, 8'hAA, 1'b1, 20'd3, 20'd3},
    '{ACT_READ,  8'h00, 8'h55, 1'b0, 20'd0, 20'd0},
    '{ACT_CLEAR, 8'h00, 8'h00, 1'b0, 20'd0, 20'd0},
    '{ACT_READ,  8'h00, 8'hFF, 1'b1, 20'd0, 20'd0},
    '{ACT_READ,  8'h00, 8'hAA, 1'b1, 20'd0, 20'd0},
    '{ACT_ADD,   8'h0F, 8'hF0, 1'b0, 20'd0, 20'd0},
    '{ACT_ADD,   8'hF0, 8'h0F, 1'b0, 20'd0, 20'd0},
    '{ACT_READ,  8'h0F, 8'hF0, 1'b1, 20'd1, 20'd1},
    '{ACT_CLEAR, 8'hFF, 8'hFF, 1'b0, 20'd0, 20'd0},
    '{ACT_READ,  8'hF0, 8'h0F, 1'b1, 20'd0, 20'd0}
  };

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void tally_word(input logic [ACTION_W-1:0] act,
                                     input logic [PIXEL_W-1:0] pix,
                                     input logic [PIXEL_W-1:0] idx,
                                     output bit got, output read_t calc);
    got = 1'b0;
    calc = '0;
    case (act)
      ACT_ADD: begin
        if (hist_bins[pix] != COUNT_TOP) hist_bins[pix] = hist_bins[pix] + 1'b1;
        if (hist_bins[pix] > hist_peak) hist_peak = hist_bins[pix];
      end
      ACT_READ: begin
        got = 1'b1;
        calc.bin_count = hist_bins[idx];
        calc.peak_count = hist_peak;
      end
      ACT_CLEAR: begin
        for (int b = 0; b < BINS_DEF; b++) hist_bins[b] = '0;
        hist_peak = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic put_word(input logic [ACTION_W-1:0] act, input logic [PIXEL_W-1:0] pix,
                          input logic [PIXEL_W-1:0] idx, input logic typed,
                          input read_t typed_want);
    bit    got;
    read_t calc;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.action <= act;
    req.pixel <= pix;
    req.bin_index <= idx;
    do @(posedge clk); while (!req.ready);
    tally_word(act, pix, idx, got, calc);
    if (got) pending_reads.push_back(typed ? typed_want : calc);
    @(negedge clk);
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    read_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_reads.size() == 0) begin
        $error("result word with no read pending: bin_count %0d, peak_count %0d",
               rsp.bin_count, rsp.peak_count);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (rsp.bin_count !== want.bin_count) begin
          $error("bin_count: expected %0d, actual %0d", want.bin_count, rsp.bin_count);
          errors++;
        end
        if (rsp.peak_count !== want.peak_count) begin
          $error("peak_count: expected %0d, actual %0d", want.peak_count, rsp.peak_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int                  n;
    int                  pick;
    logic [PIXEL_W-1:0]  hot;
    logic [PIXEL_W-1:0]  pix;
    logic [PIXEL_W-1:0]  idx;
    logic [ACTION_W-1:0] act;
    rst = 1'b1;
    req.valid = 1'b0;
    req.action = ACT_ADD;
    req.pixel = '0;
    req.bin_index = '0;
    for (int b = 0; b < BINS_DEF; b++) hist_bins[b] = '0;
    hist_peak = '0;
    hot = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      put_word(plan[r].action, plan[r].pixel, plan[r].bin_index, plan[r].typed,
               '{plan[r].bin_count, plan[r].peak_count});
    end

    n = 0;
    while (n < RANDOM_WORDS) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n % 64 == 0) hot = PIXEL_W'($urandom_range(255));
      pix = $urandom_range(1) ? PIXEL_W'(hot + $urandom_range(3))
                              : PIXEL_W'($urandom_range(255));
      idx = $urandom_range(2) != 0 ? PIXEL_W'(hot + $urandom_range(3))
                                   : PIXEL_W'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 2) act = ACT_CLEAR;
      else if (pick < 4) act = ACT_SPARE;
      else if (pick < 34) act = ACT_READ;
      else act = ACT_ADD;
      put_word(act, pix, idx, 1'b0, '0);
      if (act != ACT_SPARE) n++;
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    wait (pending_reads.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ghp_pkg.sv
design/ghp_if.sv
design/ghp_ctrl.sv
design/ghp_datapath.sv
design/gray_histogram_with_peak.sv
design/ghp_checker.sv
verif/tb_gray_histogram_with_peak.sv
